FILE: hw/rtl/pai_pkg.sv
`default_nettype none

package pai_pkg;

    localparam int CNT_W   = 7;
    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int DEPTH_DEFAULT = 64;

    // command codes on the input
    localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DISPLAY = 2'd2;

    // classified operations
    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_DELETE  = 2'd1;
    localparam logic [1:0] OP_DISPLAY = 2'd2;
    localparam logic [1:0] OP_INVALID = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef struct packed {
        logic [1:0]        op;
        logic              pos_zero;
        logic [POS_W-1:0]  pos_idx;
        logic [WORD_W-1:0] value;
    } pai_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/positional_array_insert_delete.sv
// Channel  | Dir | Signals                     | Contents
// s_axis   | in  | tvalid tready tdata tuser   | command, position, new_value
// m_axis   | out | tvalid tready tdata tuser   | status, element, fill_count,
//          |     | tlast                       | last
//
// A request passes a classify register and a two-entry queue before the
// execute stage, whose output registers hold its result for m_axis.
// Insert and delete shift all cells at once; display gives one entry
// per cycle as the cells rotate, while the output is not stalled.
// Reset clears the fill count and control; entry cells are not cleared.
// Output stalls back up through the queue to s_axis_tready.
`default_nettype none

module positional_array_insert_delete
    import pai_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // position[6:0], new_value[38:7]
    input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // element[31:0], fill_count[38:32]
    output logic [1:0]       m_axis_tuser,   // status[1:0]
    output logic             m_axis_tlast
);

    logic        push_valid;
    logic        push_ready;
    pai_item_t   push_item;
    logic        q_valid;
    logic        q_pop;
    pai_item_t   q_item;
    logic [WORD_W-1:0] element;
    logic [CNT_W-1:0]  fill_count;

    pai_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_command  (s_axis_tuser),
        .in_position (s_axis_tdata[6:0]),
        .in_value    (s_axis_tdata[38:7]),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    pai_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_item  (push_item),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_item  (q_item)
    );

    pai_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_pop       (q_pop),
        .q_item      (q_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (m_axis_tuser),
        .out_element (element),
        .out_count   (fill_count),
        .out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, fill_count, element};

endmodule

`default_nettype wire

FILE: hw/rtl/pai_front.sv
`default_nettype none

module pai_front
    import pai_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  in_command,
    input  wire logic [POS_W-1:0]  in_position,
    input  wire logic [WORD_W-1:0] in_value,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output pai_item_t              push_item
);

    logic      valid_reg;
    logic      valid_next;
    pai_item_t item_reg;
    pai_item_t item_next;

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        unique case (in_command)
            CMD_INSERT:  item_next.op = OP_INSERT;
            CMD_DELETE:  item_next.op = OP_DELETE;
            CMD_DISPLAY: item_next.op = OP_DISPLAY;
            default:     item_next.op = OP_INVALID;
        endcase
        item_next.pos_zero = (in_position == '0);
        item_next.pos_idx  = in_position - POS_W'(1);
        item_next.value    = in_value;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pai_queue.sv
`default_nettype none

module pai_queue
    import pai_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_valid,
    output logic           wr_ready,
    input  wire pai_item_t wr_item,
    output logic           rd_valid,
    input  wire logic      rd_pop,
    output pai_item_t      rd_item
);

    localparam int QCNT_W = $clog2(Q_DEPTH + 1);

    pai_item_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (cnt_reg != QCNT_W'(Q_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + Q_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pai_back.sv
`default_nettype none

module pai_back
    import pai_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    output logic                    q_pop,
    input  wire pai_item_t          q_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [STAT_W-1:0]       out_status,
    output logic [WORD_W-1:0]       out_element,
    output logic [CNT_W-1:0]        out_count,
    output logic                    out_last
);

    logic [WORD_W-1:0] cell_reg  [DEPTH];
    logic [WORD_W-1:0] cell_next [DEPTH];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              disp_reg;
    logic              disp_next;
    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  left_next;

    logic              ovalid_reg;
    logic              ovalid_next;
    logic [STAT_W-1:0] ostat_reg;
    logic [STAT_W-1:0] ostat_next;
    logic [WORD_W-1:0] oelem_reg;
    logic [WORD_W-1:0] oelem_next;
    logic [CNT_W-1:0]  ocnt_reg;
    logic [CNT_W-1:0]  ocnt_next;
    logic              olast_reg;
    logic              olast_next;

    logic              load;
    logic              shift_ins;
    logic              shift_del;
    logic              rotate;
    logic [CNT_W-1:0]  rot_end;
    logic [CNT_W-1:0]  p_idx;

    assign load        = !ovalid_reg || out_ready;
    assign q_pop       = load && !disp_reg && q_valid;
    assign rot_end     = count_reg - CNT_W'(1);
    assign p_idx       = CNT_W'(q_item.pos_idx);
    assign out_valid   = ovalid_reg;
    assign out_status  = ostat_reg;
    assign out_element = oelem_reg;
    assign out_count   = ocnt_reg;
    assign out_last    = olast_reg;

    always_comb
    begin
        count_next  = count_reg;
        disp_next   = disp_reg;
        left_next   = left_reg;
        ovalid_next = ovalid_reg;
        ostat_next  = ostat_reg;
        oelem_next  = oelem_reg;
        ocnt_next   = ocnt_reg;
        olast_next  = olast_reg;
        shift_ins   = 1'b0;
        shift_del   = 1'b0;
        rotate      = 1'b0;
        if (load)
        begin
            ovalid_next = 1'b0;
            if (disp_reg)
            begin
                rotate      = 1'b1;
                ovalid_next = 1'b1;
                ostat_next  = ST_OK;
                oelem_next  = cell_reg[0];
                ocnt_next   = count_reg;
                olast_next  = (left_reg == '0);
                left_next   = left_reg - CNT_W'(1);
                disp_next   = (left_reg != '0);
            end
            else if (q_valid)
            begin
                ovalid_next = 1'b1;
                ostat_next  = ST_OK;
                oelem_next  = '0;
                ocnt_next   = count_reg;
                olast_next  = 1'b1;
                unique case (q_item.op)
                    OP_INSERT:
                    begin
                        if (count_reg >= CNT_W'(DEPTH))
                        begin
                            ostat_next = ST_FULL;
                        end
                        else if (q_item.pos_zero || p_idx > count_reg)
                        begin
                            ostat_next = ST_BADPOS;
                        end
                        else
                        begin
                            shift_ins  = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            ocnt_next  = count_next;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (count_reg == '0)
                        begin
                            ostat_next = ST_EMPTY;
                        end
                        else if (q_item.pos_zero || p_idx >= count_reg)
                        begin
                            ostat_next = ST_BADPOS;
                        end
                        else
                        begin
                            shift_del  = 1'b1;
                            count_next = count_reg - CNT_W'(1);
                            ocnt_next  = count_next;
                        end
                    end
                    OP_DISPLAY:
                    begin
                        if (count_reg == '0)
                        begin
                            ostat_next = ST_EMPTY;
                        end
                        else
                        begin
                            // first entry now, rest from the rotating cells
                            rotate     = 1'b1;
                            oelem_next = cell_reg[0];
                            olast_next = (rot_end == '0);
                            left_next  = rot_end - CNT_W'(1);
                            disp_next  = (rot_end != '0);
                        end
                    end
                    default:
                    begin
                        ostat_next = ST_BADPOS;
                    end
                endcase
            end
        end
    end

    // each cell looks only at its neighbors, cell 0, the new value and the shared controls
    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_cell
        localparam int NXT = (gi + 1 < DEPTH) ? gi + 1 : gi;
        localparam int PRV = (gi > 0) ? gi - 1 : 0;
        localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);

        always_comb
        begin
            cell_next[gi] = cell_reg[gi];
            if (shift_ins)
            begin
                if (IDX > p_idx)
                begin
                    cell_next[gi] = cell_reg[PRV];
                end
                else if (IDX == p_idx)
                begin
                    cell_next[gi] = q_item.value;
                end
            end
            else if (shift_del)
            begin
                if (IDX >= p_idx)
                begin
                    cell_next[gi] = cell_reg[NXT];
                end
            end
            else if (rotate)
            begin
                if (IDX == rot_end)
                begin
                    cell_next[gi] = cell_reg[0];
                end
                else if (IDX < rot_end)
                begin
                    cell_next[gi] = cell_reg[NXT];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            cell_reg[k] <= cell_next[k];
        end
        ostat_reg <= ostat_next;
        oelem_reg <= oelem_next;
        ocnt_reg  <= ocnt_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            disp_reg   <= 1'b0;
            left_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            disp_reg   <= disp_next;
            left_reg   <= left_next;
            ovalid_reg <= ovalid_next;
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_disp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        disp_reg |-> (count_reg != '0) && (left_reg < count_reg))
        else $error("display run on bad count");

    a_disp_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        disp_reg |=> (count_reg == $past(count_reg)))
        else $error("count changed during display");

    a_no_pop_in_disp: assert property (@(posedge clk) disable iff (!rst_n)
        disp_reg |-> !q_pop)
        else $error("request popped during display");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import pai_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEFAULT;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] element;
        logic [CNT_W-1:0]  fill_count;
        logic              last;
    } list_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;
        logic              typed;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  fill_count;
    } request_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;     // position[6:0], new_value[38:7]
    logic [1:0]  s_axis_tuser = '0;     // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;          // element[31:0], fill_count[38:32]
    logic [1:0]  m_axis_tuser;          // status[1:0]
    logic        m_axis_tlast;

    logic [WORD_W-1:0] list_words [LIST_DEPTH];
    int                list_len = 0;
    list_result_t      step_results [$];
    list_result_t      expected_results [$];

    int mismatch_count = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    // Directed requests: typed rows carry their single expected result.
    request_row_t plan [17] = '{
        '{CMD_DISPLAY, 7'd0,   32'h0,        1'b1, ST_EMPTY,  7'd0},
        '{CMD_DELETE,  7'd1,   32'h0,        1'b1, ST_EMPTY,  7'd0},
        '{CMD_INSERT,  7'd0,   32'h5,        1'b1, ST_BADPOS, 7'd0},
        '{CMD_INSERT,  7'd2,   32'h5,        1'b1, ST_BADPOS, 7'd0},
        '{CMD_UNUSED,  7'd0,   32'h0,        1'b1, ST_BADPOS, 7'd0},
        '{CMD_INSERT,  7'd1,   32'h7fffffff, 1'b1, ST_OK,     7'd1},
        '{CMD_INSERT,  7'd1,   32'h80000000, 1'b1, ST_OK,     7'd2},
        '{CMD_INSERT,  7'd3,   32'hffffffff, 1'b1, ST_OK,     7'd3},
        '{CMD_INSERT,  7'd2,   32'h0,        1'b1, ST_OK,     7'd4},
        '{CMD_INSERT,  7'd127, 32'h1234,     1'b1, ST_BADPOS, 7'd4},
        '{CMD_DISPLAY, 7'd0,   32'h0,        1'b0, ST_OK,     7'd0},
        '{CMD_DELETE,  7'd0,   32'h0,        1'b1, ST_BADPOS, 7'd4},
        '{CMD_DELETE,  7'd5,   32'h0,        1'b1, ST_BADPOS, 7'd4},
        '{CMD_DELETE,  7'd4,   32'h0,        1'b1, ST_OK,     7'd3},
        '{CMD_DELETE,  7'd1,   32'h0,        1'b1, ST_OK,     7'd2},
        '{CMD_DISPLAY, 7'd0,   32'h0,        1'b0, ST_OK,     7'd0},
        '{CMD_UNUSED,  7'd127, 32'hffffffff, 1'b1, ST_BADPOS, 7'd2}
    };

    int send_idle_by_phase [4] = '{0, 85, 0, 33};
    int recv_stall_by_phase [4] = '{0, 0, 85, 33};
    int insert_pct_by_phase [4] = '{80, 30, 75, 20};
    int delete_pct_by_phase [4] = '{8, 55, 10, 65};

    positional_array_insert_delete DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void note_result(input logic [STAT_W-1:0] status,
                                        input logic [WORD_W-1:0] element,
                                        input logic last);
        step_results.push_back('{status, element, list_len[CNT_W-1:0], last});
    endfunction

    task automatic predict_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                   input logic [WORD_W-1:0] value);
        int slot;
        slot = pos;
        step_results.delete();
        case (cmd)
            CMD_INSERT:
                if (list_len >= LIST_DEPTH)
                    note_result(ST_FULL, '0, 1'b1);
                else if (slot < 1 || slot > list_len + 1)
                    note_result(ST_BADPOS, '0, 1'b1);
                else
                begin
                    for (int i = list_len; i >= slot; i--)
                        list_words[i] = list_words[i-1];
                    list_words[slot-1] = value;
                    list_len++;
                    note_result(ST_OK, '0, 1'b1);
                end
            CMD_DELETE:
                if (list_len == 0)
                    note_result(ST_EMPTY, '0, 1'b1);
                else if (slot < 1 || slot > list_len)
                    note_result(ST_BADPOS, '0, 1'b1);
                else
                begin
                    for (int i = slot - 1; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    note_result(ST_OK, '0, 1'b1);
                end
            CMD_DISPLAY:
                if (list_len == 0)
                    note_result(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < list_len; i++)
                        note_result(ST_OK, list_words[i], i == list_len - 1);
            default:
                note_result(ST_BADPOS, '0, 1'b1);
        endcase
    endtask

    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] value, input logic typed,
                                input logic [STAT_W-1:0] status,
                                input logic [CNT_W-1:0] fill_count);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {1'b0, value, pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_request(cmd, pos, value);
        if (typed)
            expected_results.push_back('{status, 32'd0, fill_count, 1'b1});
        else
            foreach (step_results[i])
                expected_results.push_back(step_results[i]);
    endtask

    task automatic check_result();
        list_result_t want;
        if (expected_results.size() == 0)
        begin
            $error("result with none pending: status %0d element %h fill_count %0d",
                   m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[38:32]);
            mismatch_count++;
            return;
        end
        want = expected_results.pop_front();
        if (m_axis_tuser !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            mismatch_count++;
        end
        if (m_axis_tdata[31:0] !== want.element)
        begin
            $error("element: expected %h, got %h", want.element, m_axis_tdata[31:0]);
            mismatch_count++;
        end
        if (m_axis_tdata[38:32] !== want.fill_count)
        begin
            $error("fill_count: expected %0d, got %0d", want.fill_count, m_axis_tdata[38:32]);
            mismatch_count++;
        end
        if (m_axis_tlast !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
            mismatch_count++;
        end
    endtask

    // receiver: random stalls plus a counted hold-off
    initial
    begin
        forever
        begin
            if (hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                check_result();
        end
    end

    initial
    begin
        int roll;
        int top;
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(plan); i++)
            send_request(plan[i].cmd, plan[i].pos, plan[i].value, plan[i].typed,
                         plan[i].status, plan[i].fill_count);

        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = send_idle_by_phase[phase];
            recv_stall_pct  = recv_stall_by_phase[phase];
            // long output hold-off while requests keep coming
            if (phase == 0)
                hold_cycles = 400;
            for (int n = 0; n < 116; n++)
            begin
                roll = $urandom_range(99);
                if (roll < insert_pct_by_phase[phase])
                    cmd = CMD_INSERT;
                else if (roll < insert_pct_by_phase[phase] + delete_pct_by_phase[phase])
                    cmd = CMD_DELETE;
                else if (roll < 97)
                    cmd = CMD_DISPLAY;
                else
                    cmd = CMD_UNUSED;
                top = (cmd == CMD_INSERT) ? list_len + 1 : list_len;
                if (top == 0 || $urandom_range(9) == 0)
                    pos = $urandom_range(127);
                else
                    pos = $urandom_range(top, 1);
                case ($urandom_range(15))
                    0: value = 32'h7fffffff;
                    1: value = 32'h80000000;
                    2: value = 32'hffffffff;
                    3: value = 32'h0;
                    default: value = $urandom();
                endcase
                send_request(cmd, pos, value, 1'b0, ST_OK, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
